/* rtl/core/slx_pkg.sv */
// Shared types, token kind codes and character helpers for the script lexer.
// No dependencies; imported by every module under rtl/core.
package slx_pkg;

    // Default widths of the position and line counters
    localparam int OFFSET_BITS_DEF = 16;
    localparam int LINE_BITS_DEF   = 16;

    localparam int FIELD_BITS = 16;
    localparam int KIND_BITS  = 6;
    localparam int MAX_RES    = 4;
    localparam int KW_COUNT   = 17;
    localparam int PFX_BITS   = 48;

    // Token kinds
    localparam logic [KIND_BITS-1:0] K_LPAREN   = 6'd0;
    localparam logic [KIND_BITS-1:0] K_RPAREN   = 6'd1;
    localparam logic [KIND_BITS-1:0] K_LBRACE   = 6'd2;
    localparam logic [KIND_BITS-1:0] K_RBRACE   = 6'd3;
    localparam logic [KIND_BITS-1:0] K_COMMA    = 6'd4;
    localparam logic [KIND_BITS-1:0] K_MINUS    = 6'd5;
    localparam logic [KIND_BITS-1:0] K_PLUS     = 6'd6;
    localparam logic [KIND_BITS-1:0] K_SEMI     = 6'd7;
    localparam logic [KIND_BITS-1:0] K_SLASH    = 6'd8;
    localparam logic [KIND_BITS-1:0] K_STAR     = 6'd9;
    localparam logic [KIND_BITS-1:0] K_BANG     = 6'd10;
    localparam logic [KIND_BITS-1:0] K_IDENT    = 6'd18;
    localparam logic [KIND_BITS-1:0] K_STRING   = 6'd19;
    localparam logic [KIND_BITS-1:0] K_NUMBER   = 6'd20;
    localparam logic [KIND_BITS-1:0] K_AND      = 6'd21;
    localparam logic [KIND_BITS-1:0] K_END      = 6'd37;
    localparam logic [KIND_BITS-1:0] K_ERR_CHAR = 6'd38;
    localparam logic [KIND_BITS-1:0] K_ERR_STR  = 6'd39;

    // Comparison operator codes held while waiting for a possible '='
    localparam logic [1:0] OP_BANG = 2'd0;
    localparam logic [1:0] OP_EQ   = 2'd1;
    localparam logic [1:0] OP_GT   = 2'd2;
    localparam logic [1:0] OP_LT   = 2'd3;

    // Special characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // Keywords, right-justified in the 48-bit word prefix, in kind order
    localparam logic [PFX_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        48'("and"), 48'("class"), 48'("else"), 48'("false"), 48'("fun"),
        48'("for"), 48'("if"), 48'("nil"), 48'("or"), 48'("print"),
        48'("return"), 48'("super"), 48'("this"), 48'("true"), 48'("var"),
        48'("while"), 48'("eof_")
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd5,
        3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5, 3'd4
    };

    // One result token, fields already clipped to the port widths
    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic [FIELD_BITS-1:0] line;
    } t_token;

    // All tokens caused by one input transaction
    typedef struct packed {
        logic [2:0]               num;
        t_token [MAX_RES-1:0]     tok;
    } t_group;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alp(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == CH_UNDER);
    endfunction

    // Base kind plus one when followed by '='
    function automatic logic [KIND_BITS-1:0] oper_kind(input logic [1:0] op,
                                                      input logic paired);
        return K_BANG + {3'b000, op, paired};
    endfunction

    // Parallel compare of the word against all keywords
    function automatic logic [KIND_BITS-1:0] word_kind(input logic [PFX_BITS-1:0] pfx,
                                                      input logic [2:0] len);
        logic [KIND_BITS-1:0] k;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if ((len == KW_LEN[i]) && (pfx == KW_TEXT[i])) begin
                k = KIND_BITS'(K_AND + i);
            end
        end
        return k;
    endfunction

endpackage

/* rtl/core/slx_scan.sv */
// Scan state registers and the per-byte next-state / token logic.
// Depends on slx_pkg; produces one t_group per stepped transaction.
module slx_scan import slx_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_char_code,
    input  logic        i_no_char,
    input  logic        i_source_end,
    output t_group      o_group
);

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_OPER    = 4'd1;
    localparam logic [3:0] M_SLASH   = 4'd2;
    localparam logic [3:0] M_COMMENT = 4'd3;
    localparam logic [3:0] M_STRING  = 4'd4;
    localparam logic [3:0] M_INT     = 4'd5;
    localparam logic [3:0] M_DOT     = 4'd6;
    localparam logic [3:0] M_FRAC    = 4'd7;
    localparam logic [3:0] M_WORD    = 4'd8;

    // Emission slots in output order
    localparam int NSLOT = 6;
    localparam int SL_A  = 0;   // token closed by the new byte
    localparam int SL_B  = 1;   // stray dot after a number
    localparam int SL_C  = 2;   // single-byte token started by the new byte
    localparam int SL_D  = 3;   // pending token flushed at source end
    localparam int SL_D2 = 4;   // stray dot flushed at source end
    localparam int SL_E  = 5;   // end token
    localparam int FLUSH_FIRST = SL_D;

    logic [3:0]             r_mode,   n_mode;
    logic [OFFSET_BITS-1:0] r_ts,     n_ts;
    logic [OFFSET_BITS-1:0] r_pos,    n_pos;
    logic [LINE_BITS-1:0]   r_line,   n_line;
    logic [PFX_BITS-1:0]    r_prefix, n_prefix;
    logic [1:0]             r_oper,   n_oper;
    logic [2:0]             r_len,    n_len;
    logic [OFFSET_BITS-1:0] r_dot,    n_dot;

    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] dot_inc;
    logic [LINE_BITS-1:0]   line_inc;
    logic [LINE_BITS-1:0]   fl_line;
    logic                   go;

    logic [NSLOT-1:0]       s_v;
    logic [KIND_BITS-1:0]   s_kind [NSLOT];
    logic [OFFSET_BITS-1:0] s_beg  [NSLOT];
    logic [OFFSET_BITS-1:0] s_end  [NSLOT];

    assign pos_inc  = (r_pos == '1)  ? r_pos  : r_pos + 1'b1;
    assign dot_inc  = (r_dot == '1)  ? r_dot  : r_dot + 1'b1;
    assign line_inc = (r_line == '1) ? r_line : r_line + 1'b1;

    function automatic logic [FIELD_BITS-1:0] clip_off(input logic [OFFSET_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'hFFFF) ? '1 : w[FIELD_BITS-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] clip_line(input logic [LINE_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'hFFFF) ? '1 : w[FIELD_BITS-1:0];
    endfunction

    function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] b,
                                                    input logic [OFFSET_BITS-1:0] e);
        return (e >= b) ? e - b : '0;
    endfunction

    // Byte step, then source-end flush
    always_comb begin
        n_mode   = r_mode;
        n_ts     = r_ts;
        n_pos    = r_pos;
        n_line   = r_line;
        n_prefix = r_prefix;
        n_oper   = r_oper;
        n_len    = r_len;
        n_dot    = r_dot;
        go       = 1'b0;
        s_v      = '0;
        for (int j = 0; j < NSLOT; j++) begin
            s_kind[j] = K_END;
        end
        s_beg[SL_A] = r_ts;
        s_end[SL_A] = r_pos;
        s_beg[SL_B] = r_dot;
        s_end[SL_B] = dot_inc;
        s_kind[SL_B] = K_ERR_CHAR;
        s_beg[SL_C] = r_pos;
        s_end[SL_C] = pos_inc;
        s_beg[SL_D] = '0;
        s_end[SL_D] = '0;
        s_beg[SL_D2] = '0;
        s_end[SL_D2] = '0;
        s_kind[SL_D2] = K_ERR_CHAR;
        s_beg[SL_E] = '0;
        s_end[SL_E] = '0;
        fl_line = r_line;

        if (!i_no_char) begin
            n_pos = pos_inc;
            go    = 1'b1;
            // Close or extend the token in progress
            case (r_mode)
                M_OPER: begin
                    s_v[SL_A] = 1'b1;
                    if (i_char_code == "=") begin
                        s_kind[SL_A] = oper_kind(r_oper, 1'b1);
                        s_end[SL_A]  = pos_inc;
                        n_mode = M_IDLE;
                        go     = 1'b0;
                    end else begin
                        s_kind[SL_A] = oper_kind(r_oper, 1'b0);
                    end
                end
                M_SLASH: begin
                    if (i_char_code == "/") begin
                        n_mode = M_COMMENT;
                        go     = 1'b0;
                    end else begin
                        s_v[SL_A]    = 1'b1;
                        s_kind[SL_A] = K_SLASH;
                    end
                end
                M_COMMENT: begin
                    go = (i_char_code == CH_NL);
                end
                M_STRING: begin
                    go = 1'b0;
                    if (i_char_code == CH_NL) begin
                        n_line = line_inc;
                    end
                    if (i_char_code == CH_QUOTE) begin
                        s_v[SL_A]    = 1'b1;
                        s_kind[SL_A] = K_STRING;
                        s_end[SL_A]  = pos_inc;
                        n_mode = M_IDLE;
                    end
                end
                M_INT: begin
                    if (is_dig(i_char_code)) begin
                        go = 1'b0;
                    end else if (i_char_code == ".") begin
                        n_dot  = r_pos;
                        n_mode = M_DOT;
                        go     = 1'b0;
                    end else begin
                        s_v[SL_A]    = 1'b1;
                        s_kind[SL_A] = K_NUMBER;
                    end
                end
                M_DOT: begin
                    if (is_dig(i_char_code)) begin
                        n_mode = M_FRAC;
                        go     = 1'b0;
                    end else begin
                        s_v[SL_A]    = 1'b1;
                        s_kind[SL_A] = K_NUMBER;
                        s_end[SL_A]  = r_dot;
                        s_v[SL_B]    = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (is_dig(i_char_code)) begin
                        go = 1'b0;
                    end else begin
                        s_v[SL_A]    = 1'b1;
                        s_kind[SL_A] = K_NUMBER;
                    end
                end
                M_WORD: begin
                    if (is_alp(i_char_code) || is_dig(i_char_code)) begin
                        n_prefix = {r_prefix[PFX_BITS-9:0], i_char_code};
                        if (r_len < 3'd7) begin
                            n_len = r_len + 3'd1;
                        end
                        go = 1'b0;
                    end else begin
                        s_v[SL_A]    = 1'b1;
                        s_kind[SL_A] = word_kind(r_prefix, r_len);
                    end
                end
                default: begin
                end
            endcase

            // Start a new token with this byte
            if (go) begin
                n_ts   = r_pos;
                n_mode = M_IDLE;
                case (i_char_code)
                    "(": begin s_v[SL_C] = 1'b1; s_kind[SL_C] = K_LPAREN; end
                    ")": begin s_v[SL_C] = 1'b1; s_kind[SL_C] = K_RPAREN; end
                    "{": begin s_v[SL_C] = 1'b1; s_kind[SL_C] = K_LBRACE; end
                    "}": begin s_v[SL_C] = 1'b1; s_kind[SL_C] = K_RBRACE; end
                    ",": begin s_v[SL_C] = 1'b1; s_kind[SL_C] = K_COMMA;  end
                    "-": begin s_v[SL_C] = 1'b1; s_kind[SL_C] = K_MINUS;  end
                    "+": begin s_v[SL_C] = 1'b1; s_kind[SL_C] = K_PLUS;   end
                    ";": begin s_v[SL_C] = 1'b1; s_kind[SL_C] = K_SEMI;   end
                    "*": begin s_v[SL_C] = 1'b1; s_kind[SL_C] = K_STAR;   end
                    "!": begin n_oper = OP_BANG; n_mode = M_OPER; end
                    "=": begin n_oper = OP_EQ;   n_mode = M_OPER; end
                    ">": begin n_oper = OP_GT;   n_mode = M_OPER; end
                    "<": begin n_oper = OP_LT;   n_mode = M_OPER; end
                    "/": n_mode = M_SLASH;
                    " ", CH_CR, CH_TAB: begin
                    end
                    CH_NL: n_line = line_inc;
                    CH_QUOTE: n_mode = M_STRING;
                    default: begin
                        if (is_dig(i_char_code)) begin
                            n_mode = M_INT;
                        end else if (is_alp(i_char_code)) begin
                            n_mode   = M_WORD;
                            n_prefix = {{(PFX_BITS-8){1'b0}}, i_char_code};
                            n_len    = 3'd1;
                        end else begin
                            s_v[SL_C]    = 1'b1;
                            s_kind[SL_C] = K_ERR_CHAR;
                        end
                    end
                endcase
            end
        end

        // Flush at source end, then back to reset values
        if (i_source_end) begin
            fl_line     = n_line;
            s_beg[SL_D] = n_ts;
            s_end[SL_D] = n_pos;
            s_beg[SL_D2] = n_dot;
            s_end[SL_D2] = (n_dot == '1) ? n_dot : n_dot + 1'b1;
            s_beg[SL_E] = n_pos;
            s_end[SL_E] = n_pos;
            s_v[SL_E]   = 1'b1;
            case (n_mode)
                M_OPER: begin
                    s_v[SL_D] = 1'b1; s_kind[SL_D] = oper_kind(n_oper, 1'b0);
                end
                M_SLASH: begin
                    s_v[SL_D] = 1'b1; s_kind[SL_D] = K_SLASH;
                end
                M_STRING: begin
                    s_v[SL_D] = 1'b1; s_kind[SL_D] = K_ERR_STR;
                end
                M_INT, M_FRAC: begin
                    s_v[SL_D] = 1'b1; s_kind[SL_D] = K_NUMBER;
                end
                M_DOT: begin
                    s_v[SL_D]   = 1'b1;
                    s_kind[SL_D] = K_NUMBER;
                    s_end[SL_D] = n_dot;
                    s_v[SL_D2]  = 1'b1;
                end
                M_WORD: begin
                    s_v[SL_D] = 1'b1; s_kind[SL_D] = word_kind(n_prefix, n_len);
                end
                default: begin
                end
            endcase
            n_mode   = M_IDLE;
            n_ts     = '0;
            n_pos    = '0;
            n_line   = LINE_BITS'(1);
            n_prefix = '0;
            n_oper   = OP_BANG;
            n_len    = '0;
            n_dot    = '0;
        end
    end

    // Pack active slots in order into the result group
    always_comb begin
        o_group = '0;
        for (int j = 0; j < NSLOT; j++) begin
            if (s_v[j] && (o_group.num < 3'(MAX_RES))) begin
                o_group.tok[o_group.num[1:0]].kind   = s_kind[j];
                o_group.tok[o_group.num[1:0]].start  = clip_off(s_beg[j]);
                o_group.tok[o_group.num[1:0]].length = clip_off(span(s_beg[j], s_end[j]));
                o_group.tok[o_group.num[1:0]].line   =
                    clip_line((j < FLUSH_FIRST) ? r_line : fl_line);
                o_group.num = o_group.num + 3'd1;
            end
        end
    end

    // Scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_ts     <= '0;
            r_pos    <= '0;
            r_line   <= LINE_BITS'(1);
            r_prefix <= '0;
            r_oper   <= OP_BANG;
            r_len    <= '0;
            r_dot    <= '0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_ts     <= n_ts;
            r_pos    <= n_pos;
            r_line   <= n_line;
            r_prefix <= n_prefix;
            r_oper   <= n_oper;
            r_len    <= n_len;
            r_dot    <= n_dot;
        end
    end

endmodule

/* rtl/core/slx_queue.sv */
// Two-entry queue of token groups, drained one token per output transaction.
// Depends on slx_pkg (t_group, t_token).
module slx_queue import slx_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_group,
    output logic   o_room,
    output logic   o_valid,
    input  logic   i_ready,
    output t_token o_token,
    output logic   o_run_last
);

    t_group     r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_cnt,    n_cnt;
    logic [1:0] r_idx,    n_idx;

    logic   do_push;
    logic   do_pop;
    logic   pop_last;
    t_group head;

    assign head       = r_mem[r_rd_ptr];
    assign o_room     = (r_cnt != 2'd2);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_token    = head.tok[r_idx];
    assign o_run_last = (r_idx == 2'(head.num - 3'd1));

    assign do_push  = i_push && o_room;
    assign do_pop   = o_valid && i_ready;
    assign pop_last = do_pop && o_run_last;

    // Pointer, count and token index update
    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop_last ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, do_push} - {1'b0, pop_last};
        n_idx    = pop_last ? 2'd0 : (do_pop ? r_idx + 2'd1 : r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
            r_idx    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
        end
    end

    // Group storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

endmodule

/* rtl/core/script_lexer_tokenizer.sv */
// Streaming lexer: one source byte per input transaction, up to four tokens out.
// A byte is accepted every cycle while the two-entry group queue has room; the
// token passes through the input register, then the scan logic into the queue.
// Each token takes its own output transaction; sustained input rate is one byte
// per cycle as long as bytes average at most one token each and the output side
// is ready.
// Depends on slx_pkg, slx_scan and slx_queue.
module script_lexer_tokenizer import slx_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_char_code,
    input  logic                  i_no_char,
    input  logic                  i_source_end,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [KIND_BITS-1:0]  o_token_kind,
    output logic [FIELD_BITS-1:0] o_start_offset,
    output logic [FIELD_BITS-1:0] o_lexeme_length,
    output logic [FIELD_BITS-1:0] o_line_number,
    output logic                  o_run_last
);

    logic       r_in_vld;
    logic [7:0] r_char;
    logic       r_no_char;
    logic       r_src_end;

    logic   q_room;
    logic   adv;
    t_group grp;
    t_token tok;

    assign adv     = r_in_vld && q_room;
    assign o_ready = !r_in_vld || q_room;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char    <= i_char_code;
            r_no_char <= i_no_char;
            r_src_end <= i_source_end;
        end
    end

    slx_scan #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (adv),
        .i_char_code  (r_char),
        .i_no_char    (r_no_char),
        .i_source_end (r_src_end),
        .o_group      (grp)
    );

    slx_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (adv && (grp.num != 3'd0)),
        .i_group    (grp),
        .o_room     (q_room),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_token    (tok),
        .o_run_last (o_run_last)
    );

    assign o_token_kind    = tok.kind;
    assign o_start_offset  = tok.start;
    assign o_lexeme_length = tok.length;
    assign o_line_number   = tok.line;

    // Checks
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_token_kind <= K_ERR_STR))
        else $error("token kind out of range");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_line_number != '0))
        else $error("line number zero");

    a_punct_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_token_kind <= K_SEMI)) |-> (o_lexeme_length <= 16'd1))
        else $error("single punctuation longer than one byte");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for script_lexer_tokenizer: byte streams in over valid/ready,
// every token checked against an in-bench token predictor held in a scoreboard class.
// Depends on slx_pkg and the script_lexer_tokenizer RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import slx_pkg::*;

    // Comparison kinds without a package name; the paired form is one above
    localparam logic [KIND_BITS-1:0] KIND_EQUAL   = 6'd12;
    localparam logic [KIND_BITS-1:0] KIND_GREATER = 6'd14;
    localparam logic [KIND_BITS-1:0] KIND_LESS    = 6'd16;

    localparam int unsigned POS_LIMIT   = (1 << OFFSET_BITS_DEF) - 1;
    localparam int unsigned LINE_LIMIT  = (1 << LINE_BITS_DEF) - 1;
    localparam int unsigned FIELD_LIMIT = (1 << FIELD_BITS) - 1;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int RANDOM_BYTES = 30;

    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_OPER, SCAN_SLASH, SCAN_COMMENT, SCAN_STRING,
        SCAN_INT, SCAN_DOT, SCAN_FRAC, SCAN_WORD
    } scan_mode_e;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic [FIELD_BITS-1:0] line;
        logic                  last;
    } token_rec_t;

    // Token predictor plus the queue of tokens still owed by the block
    class token_scoreboard;
        scan_mode_e          mode;
        int unsigned         tok_start;
        int unsigned         pos;
        int unsigned         line_cnt;
        int unsigned         dot_off;
        int unsigned         word_len;
        logic [PFX_BITS-1:0] word_pfx;
        logic [7:0]          held;
        string               kw_words [KW_COUNT];
        token_rec_t          expect_q [$];
        token_rec_t          step_q [$];
        int                  errors;

        function new();
            // Keyword kinds run upward from K_AND in this order
            kw_words = '{"and", "class", "else", "false", "fun", "for", "if", "nil", "or",
                         "print", "return", "super", "this", "true", "var", "while", "eof_"};
            errors = 0;
            restart();
        endfunction

        function void restart();
            mode      = SCAN_IDLE;
            tok_start = 0;
            pos       = 0;
            line_cnt  = 1;
            dot_off   = 0;
            word_len  = 0;
            word_pfx  = '0;
            held      = '0;
        endfunction

        function int pending();
            return expect_q.size();
        endfunction

        static function int unsigned bump(int unsigned v, int unsigned lim);
            return (v >= lim) ? lim : v + 1;
        endfunction

        static function logic [FIELD_BITS-1:0] clip(int unsigned v);
            return (v > FIELD_LIMIT) ? FIELD_BITS'(FIELD_LIMIT) : FIELD_BITS'(v);
        endfunction

        static function bit is_digit_ch(logic [7:0] c);
            return (c >= "0") && (c <= "9");
        endfunction

        static function bit is_alpha_ch(logic [7:0] c);
            return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_UNDER);
        endfunction

        function void push_token(logic [KIND_BITS-1:0] kind, int unsigned first,
                                 int unsigned stop);
            token_rec_t t;
            if (step_q.size() >= MAX_RES) return;
            t.kind   = kind;
            t.start  = clip(first);
            t.length = clip((stop >= first) ? stop - first : 0);
            t.line   = clip(line_cnt);
            t.last   = 1'b0;
            step_q.push_back(t);
        endfunction

        function logic [KIND_BITS-1:0] compare_kind(logic [7:0] c, bit paired);
            logic [KIND_BITS-1:0] base;
            case (c)
                "!":     base = K_BANG;
                "=":     base = KIND_EQUAL;
                ">":     base = KIND_GREATER;
                default: base = KIND_LESS;
            endcase
            return paired ? base + 1'b1 : base;
        endfunction

        // Length must match too, so a long word ending in a keyword stays an identifier
        function logic [KIND_BITS-1:0] word_class();
            logic [PFX_BITS-1:0] kw_bits;
            for (int i = 0; i < KW_COUNT; i++) begin
                kw_bits = '0;
                for (int n = 0; n < kw_words[i].len(); n++) begin
                    kw_bits = {kw_bits[PFX_BITS-9:0], kw_words[i][n]};
                end
                if ((word_len == kw_words[i].len()) && (kw_bits == word_pfx)) begin
                    return K_AND + KIND_BITS'(i);
                end
            end
            return K_IDENT;
        endfunction

        // Byte seen from idle: single tokens go out at once, others open a mode
        function void begin_token(logic [7:0] c, int unsigned p, int unsigned e);
            tok_start = p;
            mode      = SCAN_IDLE;
            case (c)
                "(": push_token(K_LPAREN, p, e);
                ")": push_token(K_RPAREN, p, e);
                "{": push_token(K_LBRACE, p, e);
                "}": push_token(K_RBRACE, p, e);
                ",": push_token(K_COMMA, p, e);
                "-": push_token(K_MINUS, p, e);
                "+": push_token(K_PLUS, p, e);
                ";": push_token(K_SEMI, p, e);
                "*": push_token(K_STAR, p, e);
                "!", "=", "<", ">": begin
                    held = c;
                    mode = SCAN_OPER;
                end
                "/":      mode = SCAN_SLASH;
                " ", CH_CR, CH_TAB: begin
                end
                CH_NL:    line_cnt = bump(line_cnt, LINE_LIMIT);
                CH_QUOTE: mode = SCAN_STRING;
                default: begin
                    if (is_digit_ch(c)) begin
                        mode = SCAN_INT;
                    end else if (is_alpha_ch(c)) begin
                        mode     = SCAN_WORD;
                        word_pfx = PFX_BITS'(c);
                        word_len = 1;
                    end else begin
                        push_token(K_ERR_CHAR, p, e);
                    end
                end
            endcase
        endfunction

        // One source byte; lookahead closes the pending token, then the byte restarts
        function void feed_byte(logic [7:0] c);
            int unsigned p;
            int unsigned e;
            p   = pos;
            e   = bump(p, POS_LIMIT);
            pos = e;
            case (mode)
                SCAN_OPER: begin
                    if (c == "=") begin
                        push_token(compare_kind(held, 1'b1), tok_start, e);
                        mode = SCAN_IDLE;
                        return;
                    end
                    push_token(compare_kind(held, 1'b0), tok_start, p);
                end
                SCAN_SLASH: begin
                    if (c == "/") begin
                        mode = SCAN_COMMENT;
                        return;
                    end
                    push_token(K_SLASH, tok_start, p);
                end
                SCAN_COMMENT: begin
                    if (c != CH_NL) return;
                end
                SCAN_STRING: begin
                    if (c == CH_NL) line_cnt = bump(line_cnt, LINE_LIMIT);
                    if (c == CH_QUOTE) begin
                        push_token(K_STRING, tok_start, e);
                        mode = SCAN_IDLE;
                    end
                    return;
                end
                SCAN_INT: begin
                    if (is_digit_ch(c)) return;
                    if (c == ".") begin
                        dot_off = p;
                        mode    = SCAN_DOT;
                        return;
                    end
                    push_token(K_NUMBER, tok_start, p);
                end
                SCAN_DOT: begin
                    if (is_digit_ch(c)) begin
                        mode = SCAN_FRAC;
                        return;
                    end
                    push_token(K_NUMBER, tok_start, dot_off);
                    push_token(K_ERR_CHAR, dot_off, bump(dot_off, POS_LIMIT));
                end
                SCAN_FRAC: begin
                    if (is_digit_ch(c)) return;
                    push_token(K_NUMBER, tok_start, p);
                end
                SCAN_WORD: begin
                    if (is_alpha_ch(c) || is_digit_ch(c)) begin
                        word_pfx = {word_pfx[PFX_BITS-9:0], c};
                        if (word_len < 7) word_len++;
                        return;
                    end
                    push_token(word_class(), tok_start, p);
                end
                default: begin
                end
            endcase
            begin_token(c, p, e);
        endfunction

        // End of source: close whatever is open, then the end token
        function void flush_source();
            int unsigned p;
            p = pos;
            case (mode)
                SCAN_OPER:   push_token(compare_kind(held, 1'b0), tok_start, p);
                SCAN_SLASH:  push_token(K_SLASH, tok_start, p);
                SCAN_STRING: push_token(K_ERR_STR, tok_start, p);
                SCAN_INT, SCAN_FRAC: push_token(K_NUMBER, tok_start, p);
                SCAN_DOT: begin
                    push_token(K_NUMBER, tok_start, dot_off);
                    push_token(K_ERR_CHAR, dot_off, bump(dot_off, POS_LIMIT));
                end
                SCAN_WORD:   push_token(word_class(), tok_start, p);
                default: begin
                end
            endcase
            push_token(K_END, p, p);
        endfunction

        function void note_input(logic [7:0] c, logic nc, logic se);
            token_rec_t t;
            step_q.delete();
            if (!nc) feed_byte(c);
            if (se) begin
                flush_source();
                restart();
            end
            if (step_q.size() != 0) begin
                t      = step_q.pop_back();
                t.last = 1'b1;
                step_q.push_back(t);
            end
            foreach (step_q[i]) expect_q.push_back(step_q[i]);
        endfunction

        function void check_field(string name, logic [FIELD_BITS-1:0] want,
                                  logic [FIELD_BITS-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [KIND_BITS-1:0] kind, logic [FIELD_BITS-1:0] start,
                                   logic [FIELD_BITS-1:0] length,
                                   logic [FIELD_BITS-1:0] line, logic last);
            token_rec_t want;
            if (expect_q.size() == 0) begin
                $error("token kind %0d start %0d with no expected transaction", kind, start);
                errors++;
                return;
            end
            want = expect_q.pop_front();
            check_field("token_kind", FIELD_BITS'(want.kind), FIELD_BITS'(kind));
            check_field("start_offset", want.start, start);
            check_field("lexeme_length", want.length, length);
            check_field("line_number", want.line, line);
            check_field("run_last", FIELD_BITS'(want.last), FIELD_BITS'(last));
        endfunction
    endclass

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic [7:0]            i_char_code  = '0;
    logic                  i_no_char    = 1'b0;
    logic                  i_source_end = 1'b0;
    logic                  i_ready      = 1'b0;
    logic                  o_ready;
    logic                  o_valid;
    logic [KIND_BITS-1:0]  o_token_kind;
    logic [FIELD_BITS-1:0] o_start_offset;
    logic [FIELD_BITS-1:0] o_lexeme_length;
    logic [FIELD_BITS-1:0] o_line_number;
    logic                  o_run_last;

    token_scoreboard sb = new();

    // Sender and receiver bookkeeping
    logic [7:0] text_q [$];
    int         burst_left = 0;
    bit         steady     = 1'b0;
    int         kw_turn    = 0;
    int         hold_asks  = 0;
    int         hold_seen  = 0;
    int         hold_left  = 0;
    int         rx_mode    = 0;
    int         rx_count   = 0;
    logic [15:0] rx_pat    = 16'hFFFF;

    always #4 i_clk = ~i_clk;

    script_lexer_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_char_code     (i_char_code),
        .i_no_char       (i_no_char),
        .i_source_end    (i_source_end),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_token_kind    (o_token_kind),
        .o_start_offset  (o_start_offset),
        .o_lexeme_length (o_lexeme_length),
        .o_line_number   (o_line_number),
        .o_run_last      (o_run_last)
    );

    // Monitor: both handshakes sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_input(i_char_code, i_no_char, i_source_end);
            if (o_valid && i_ready) begin
                sb.check_result(o_token_kind, o_start_offset, o_lexeme_length,
                                o_line_number, o_run_last);
            end
        end
    end

    // Receiver: long hold-off on request, otherwise a changing stall pattern
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else if (hold_seen != hold_asks) begin
            hold_seen = hold_seen + 1;
            hold_left = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else begin
            if (rx_count == 0) begin
                rx_mode  = $urandom_range(0, 3);
                rx_pat   = $urandom;
                rx_count = $urandom_range(16, 80);
            end else begin
                rx_count = rx_count - 1;
            end
            case (rx_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                2: begin
                    i_ready <= rx_pat[0];
                    rx_pat = {rx_pat[0], rx_pat[15:1]};
                end
                default: i_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // One input transaction; entered and left at a falling edge
    task automatic send_item(input logic [7:0] c, input logic nc, input logic se);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid     <= 1'b0;
                i_char_code <= 8'($urandom);
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_char_code  <= c;
        i_no_char    <= nc;
        i_source_end <= se;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic send_text();
        while (text_q.size() != 0) send_item(text_q.pop_front(), 1'b0, 1'b0);
    endtask

    task automatic send_end(input logic [7:0] c, input logic nc);
        send_text();
        send_item(c, nc, 1'b1);
    endtask

    // Sender pause until every owed token has come out
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        burst_left = 0;
    endtask

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // Random lexeme, at times an open string, a bare trailing dot or a noise byte
    task automatic add_random_token();
        string      ops = "(){},-+;*/!=<>";
        int         pick;
        int         n;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            add_text(sb.kw_words[kw_turn % KW_COUNT]);
            kw_turn++;
        end else if (pick < 40) begin
            n = $urandom_range(1, 9);
            text_q.push_back(rand_alpha());
            repeat (n - 1) text_q.push_back(($urandom_range(0, 3) == 0) ? rand_digit()
                                                                       : rand_alpha());
        end else if (pick < 53) begin
            repeat ($urandom_range(1, 4)) text_q.push_back(rand_digit());
            n = $urandom_range(0, 3);
            if (n == 0) begin
                text_q.push_back(".");
                repeat ($urandom_range(1, 3)) text_q.push_back(rand_digit());
            end else if (n == 1) begin
                text_q.push_back(".");
            end
        end else if (pick < 61) begin
            text_q.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 6)) begin
                c = 8'($urandom_range(8'h20, 8'h7E));
                text_q.push_back((c == CH_QUOTE) ? CH_NL : c);
            end
            if ($urandom_range(0, 9) != 0) text_q.push_back(CH_QUOTE);
        end else if (pick < 76) begin
            text_q.push_back(ops[$urandom_range(0, ops.len() - 1)]);
            if ($urandom_range(0, 4) < 2) text_q.push_back("=");
        end else if (pick < 81) begin
            add_text("//");
            repeat ($urandom_range(0, 5)) text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            text_q.push_back(CH_NL);
        end else if (pick < 90) begin
            case ($urandom_range(0, 3))
                0:       text_q.push_back(" ");
                1:       text_q.push_back(CH_TAB);
                2:       text_q.push_back(CH_CR);
                default: text_q.push_back(CH_NL);
            endcase
        end else begin
            text_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Hard stop in case the block hangs
    initial begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int rand_bytes;
        int tokens;
        int pick;
        int n;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every punctuation, open slash closed by a byte-less end
        add_text("(){},-+;*/");
        send_end(8'h00, 1'b1);
        // Comparison forms but a lone '='; the end byte pairs the last one
        add_text("!!===>>=<<");
        send_end("=", 1'b0);
        // Fraction, dot without digit, blanks, extreme bytes, byte-less item
        add_text("9.5 7.x\t");
        text_q.push_back(CH_CR);
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        send_text();
        send_item(8'hFF, 1'b1, 1'b0);
        // End keyword, comment, string over a newline, trailing dot at source end
        add_text("eof_//c\n\"a\nb\"4.");
        send_end(8'h00, 1'b1);
        // String left open at source end
        add_text("\"ab");
        send_end("c", 1'b0);

        // Random lexeme streams with idling, one long output hold-off and one drain
        rand_bytes = 0;
        tokens     = 0;
        while ((rand_bytes < RANDOM_BYTES) || (tokens < 8)) begin
            if (tokens % 5 == 0) steady = !steady;
            if (tokens == 2) hold_asks++;
            if (tokens == 6) wait_idle();
            pick = $urandom_range(0, 99);
            if (pick < 94) begin
                add_random_token();
                if ($urandom_range(0, 1) != 0) text_q.push_back(" ");
                rand_bytes += text_q.size();
                send_text();
            end else if (pick < 97) begin
                send_item(8'($urandom), 1'b1, 1'b0);
            end else begin
                rand_bytes++;
                send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
            end
            tokens++;
        end
        send_item(8'h00, 1'b1, 1'b1);

        // Word longer than the prefix, dot before a letter, string open at the end
        add_text("abcdefg;");
        add_text("12.x\"ab");
        send_end(8'h00, 1'b1);

        // Drain and report
        i_valid <= 1'b0;
        n = 0;
        do begin
            @(negedge i_clk);
            n++;
        end while ((sb.pending() != 0) && (n < DRAIN_LIMIT));
        repeat (16) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected tokens never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
